[rtl/bpmc_pkg.sv]
// Shared types and constants of the button press mode cycler.
// No dependencies; compile first.
package bpmc_pkg;

   localparam int TimeBits = 32;
   localparam int CfgBits  = 16;

   typedef logic [TimeBits-1:0] time_type;
   typedef logic [CfgBits-1:0]  cfg_word_type;
   typedef logic [1:0]          mode_type;

   // Play mode codes
   localparam mode_type ModeOff    = 2'd0;
   localparam mode_type ModeChill  = 2'd1;
   localparam mode_type ModeWarmup = 2'd2;
   localparam mode_type ModeCrazy  = 2'd3;

   // Configuration register indexes
   localparam logic CsrDebounce  = 1'b0;
   localparam logic CsrLongPress = 1'b1;

   localparam cfg_word_type DebounceReset  = 16'd50;
   localparam cfg_word_type LongPressReset = 16'd1000;

   typedef struct packed {
      mode_type mode;
      logic     mode_changed;
      logic     sleep_request;
      logic     led_red_n;
      logic     led_green_n;
   } bpmc_result_type;

   // Short press step: off -> chill -> warmup -> crazy -> chill
   function automatic mode_type next_mode(input mode_type m);
      mode_type n;
      case (m)
         ModeOff:    n = ModeChill;
         ModeChill:  n = ModeWarmup;
         ModeWarmup: n = ModeCrazy;
         ModeCrazy:  n = ModeChill;
         default:    n = ModeChill;
      endcase
      return n;
   endfunction

endpackage

[rtl/bpmc_req_if.sv]
// Poll channel: valid/ready handshake carrying one button poll.
// Depends on bpmc_pkg.
interface bpmc_req_if;
   logic               valid;
   logic               ready;
   logic               button_level;
   bpmc_pkg::time_type now_ms;

   modport source (output valid, output button_level, output now_ms, input ready);
   modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

[rtl/bpmc_rsp_if.sv]
// Result channel: valid/ready handshake carrying one mode result.
// Depends on bpmc_pkg.
interface bpmc_rsp_if;
   logic               valid;
   logic               ready;
   bpmc_pkg::mode_type mode;
   logic               mode_changed;
   logic               sleep_request;
   logic               led_red_n;
   logic               led_green_n;

   modport source (output valid, output mode, output mode_changed, output sleep_request,
                   output led_red_n, output led_green_n, input ready);
   modport sink   (input valid, input mode, input mode_changed, input sleep_request,
                   input led_red_n, input led_green_n, output ready);
endinterface

[rtl/bpmc_core.sv]
// Debounce and press state of the mode cycler; one poll per step.
// Depends on bpmc_pkg.
module bpmc_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      button_level,
   input  bpmc_pkg::time_type        now_ms,
   input  bpmc_pkg::cfg_word_type    settle_ms,
   input  bpmc_pkg::cfg_word_type    long_hold_ms,
   output bpmc_pkg::bpmc_result_type result
);
   import bpmc_pkg::*;

   logic     last_level_ff, last_level_in;
   time_type change_time_ff, change_time_in;
   time_type press_start_ff, press_start_in;
   logic     press_active_ff, press_active_in;
   mode_type mode_ff, mode_in;

   time_type settle_time;
   time_type press_len;
   logic     stable;
   logic     changed;
   logic     sleep;

   always_comb begin
      last_level_in   = last_level_ff;
      change_time_in  = change_time_ff;
      press_start_in  = press_start_ff;
      press_active_in = press_active_ff;
      mode_in         = mode_ff;
      changed         = 1'b0;
      sleep           = 1'b0;

      // restart the debounce window on any level change
      if (button_level != last_level_ff) begin
         change_time_in = now_ms;
         last_level_in  = button_level;
      end
      settle_time = now_ms - change_time_in;
      press_len   = now_ms - press_start_ff;
      stable      = settle_time >= time_type'(settle_ms);

      if (stable) begin
         if (!button_level && !press_active_ff) begin
            press_start_in  = now_ms;
            press_active_in = 1'b1;
         end else if (button_level && press_active_ff) begin
            press_active_in = 1'b0;
            if (press_len >= time_type'(long_hold_ms)) begin
               sleep = 1'b1;
            end else begin
               mode_in = next_mode(mode_ff);
               changed = 1'b1;
            end
         end
      end

      result.mode          = mode_in;
      result.mode_changed  = changed;
      result.sleep_request = sleep;
      result.led_red_n     = ~mode_in[0];
      result.led_green_n   = ~mode_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff   <= 1'b1;
         change_time_ff  <= '0;
         press_start_ff  <= '0;
         press_active_ff <= 1'b0;
         mode_ff         <= ModeOff;
      end else if (step) begin
         last_level_ff   <= last_level_in;
         change_time_ff  <= change_time_in;
         press_start_ff  <= press_start_in;
         press_active_ff <= press_active_in;
         mode_ff         <= mode_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_changed_not_off: assert property (@(posedge clock) disable iff (reset)
      result.mode_changed |-> result.mode != ModeOff)
      else $error("mode advanced into off");
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      !(result.mode_changed && result.sleep_request))
      else $error("short and long press in one poll");
   a_sleep_keeps_mode: assert property (@(posedge clock) disable iff (reset)
      step && result.sleep_request |=> mode_ff == $past(mode_ff))
      else $error("long press changed the mode");
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> mode_ff == $past(mode_ff) && press_active_ff == $past(press_active_ff))
      else $error("state moved without a poll");
`endif

endmodule

[rtl/button_press_mode_cycler.sv]
// Top level of the button press mode cycler: poll register, core, result register.
// Depends on bpmc_pkg, bpmc_req_if, bpmc_rsp_if and bpmc_core.
//
//   channel | direction | carries
//   --------+-----------+------------------------------------------------
//   req     | in        | button_level, now_ms (one poll per item)
//   rsp     | out       | mode, mode_changed, sleep_request, LED drives
//   csr     | in        | write of settle time (0) or long press threshold (1)
//
// One item per clock cycle sustained while rsp is ready; each item passes the poll register, then
// the core's compares and subtracts feed the result register.
// Reset is synchronous: mode off, no press, pipeline empty, registers at
// their defaults (debounce 50 ms, long press 1000 ms).
// A stalled rsp holds the result register; the poll register keeps taking
// items only while it is empty or can hand its item on in the same cycle.
module button_press_mode_cycler (
   input  logic                   clock,
   input  logic                   reset,
   bpmc_req_if.sink               req,
   bpmc_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  bpmc_pkg::cfg_word_type csr_wdata
);
   import bpmc_pkg::*;

   // configuration registers
   cfg_word_type debounce_ff;
   cfg_word_type long_press_ff;

   // poll register
   logic     in_valid_ff;
   logic     in_level_ff;
   time_type in_now_ff;

   // result register
   logic            out_valid_ff;
   bpmc_result_type out_ff;
   bpmc_result_type out_in;

   logic out_free;
   logic step;

   // advance when the result register is empty or being drained
   assign out_free  = !out_valid_ff || rsp.ready;
   assign step      = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DebounceReset;
         long_press_ff <= LongPressReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrDebounce:  debounce_ff   <= csr_wdata;
            CsrLongPress: long_press_ff <= csr_wdata;
            default:      debounce_ff   <= debounce_ff;
         endcase
      end
   end

   // capture the item into the poll register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_level_ff <= req.button_level;
         in_now_ff   <= req.now_ms;
      end
   end

   bpmc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .button_level  (in_level_ff),
      .now_ms        (in_now_ff),
      .settle_ms     (debounce_ff),
      .long_hold_ms  (long_press_ff),
      .result        (out_in)
   );

   // load the result register; hold it while rsp stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.mode          = out_ff.mode;
   assign rsp.mode_changed  = out_ff.mode_changed;
   assign rsp.sleep_request = out_ff.sleep_request;
   assign rsp.led_red_n     = out_ff.led_red_n;
   assign rsp.led_green_n   = out_ff.led_green_n;

`ifndef NO_ASSERTIONS
   a_step_fills_out: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed item lost before the result register");
   a_leds_follow_mode: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.led_red_n == !out_ff.mode[0]
                       && out_ff.led_green_n == !out_ff.mode[1])
      else $error("LED drives disagree with mode");
   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result changed");
`endif

endmodule
